>>> hw/rtl/sat_pkg.sv
package sat_pkg;

	localparam int MAX_READ_DEF   = 32;
	localparam int MAX_GENOME_DEF = 32;
	localparam int SW             = 12;

	localparam logic [1:0] MODE_READ   = 2'd0;
	localparam logic [1:0] MODE_GENOME = 2'd1;
	localparam logic [1:0] MODE_START  = 2'd2;

	localparam logic [1:0] DIR_M   = 2'd0;
	localparam logic [1:0] DIR_I   = 2'd1;
	localparam logic [1:0] DIR_D   = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] CFG_MISMATCH = 2'd0;
	localparam logic [1:0] CFG_OPEN     = 2'd1;
	localparam logic [1:0] CFG_EXTEND   = 2'd2;

	localparam logic [2:0] WILDCARD = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_INIT,
		ST_ROWST,
		ST_CELL,
		ST_BEST,
		ST_TINIT,
		ST_TR,
		ST_TRU,
		ST_POP,
		ST_OUT,
		ST_NONE
	} state_t;

	typedef struct packed {
		logic wr_read;
		logic wr_genome;
		logic load;
		logic launch;
		logic init;
		logic row_start;
		logic cell_calc;
		logic best;
		logic trace_init;
		logic trace_step;
		logic trace_use;
		logic pop;
		logic emit;
		logic none;
	} cmd_t;

	typedef struct packed {
		logic rl_zero;
		logic gl_zero;
		logic j_eq_gl;
		logic i_eq_rl;
		logic best_done;
		logic i_zero;
		logic j_zero;
		logic sp_zero;
	} sts_t;

	function automatic logic signed [SW-1:0] border(input logic [3:0] op, input logic [3:0] ex,
			input logic [5:0] k);
		logic [SW-1:0] mag;
		mag = SW'(op) + SW'(ex) * SW'(k);
		return -$signed(mag);
	endfunction

endpackage

>>> hw/rtl/sat_ctrl.sv
module sat_ctrl
	import sat_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] mode,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy,
	output logic       strobe
);

	state_t state_q, state_d;
	logic   accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign strobe = cmd.emit || cmd.none;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.wr_read   = (mode == MODE_READ);
					cmd.wr_genome = (mode == MODE_GENOME);
					cmd.load      = (mode == MODE_START);
					if (mode == MODE_START) state_d = ST_LAUNCH;
				end
			end
			ST_LAUNCH: begin
				cmd.launch = 1'b1;
				if (sts.rl_zero) state_d = ST_NONE;
				else if (sts.gl_zero) state_d = ST_TINIT;
				else state_d = ST_INIT;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				if (sts.j_eq_gl) state_d = ST_ROWST;
			end
			ST_ROWST: begin
				cmd.row_start = 1'b1;
				state_d = ST_CELL;
			end
			ST_CELL: begin
				cmd.cell_calc = 1'b1;
				if (sts.j_eq_gl) state_d = sts.i_eq_rl ? ST_BEST : ST_ROWST;
			end
			ST_BEST: begin
				cmd.best = 1'b1;
				if (sts.best_done) state_d = ST_TINIT;
			end
			ST_TINIT: begin
				cmd.trace_init = 1'b1;
				state_d = ST_TR;
			end
			ST_TR: begin
				if (sts.i_zero && sts.j_zero) begin
					state_d = ST_POP;
				end else begin
					cmd.trace_step = 1'b1;
					if (!sts.i_zero && !sts.j_zero) state_d = ST_TRU;
				end
			end
			ST_TRU: begin
				cmd.trace_use = 1'b1;
				state_d = ST_TR;
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				cmd.emit = 1'b1;
				state_d = sts.sp_zero ? ST_IDLE : ST_POP;
			end
			ST_NONE: begin
				cmd.none = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> hw/rtl/sat_dp.sv
module sat_dp
	import sat_pkg::*;
#(
	parameter int MAX_READ   = MAX_READ_DEF,
	parameter int MAX_GENOME = MAX_GENOME_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [3:0]        cfg_data,
	input  logic [4:0]        index,
	input  logic [2:0]        symbol,
	input  logic [5:0]        read_length,
	input  logic [5:0]        genome_length,
	output logic [1:0]        op,
	output logic signed [5:0] end_position,
	output logic              last
);

	localparam int RW  = $clog2(MAX_READ + 1);
	localparam int GW  = $clog2(MAX_GENOME + 1);
	localparam int JW  = $clog2(MAX_GENOME + 2);
	localparam int SAW = $clog2(MAX_GENOME + 1);
	localparam int RIW = (MAX_READ > 1) ? $clog2(MAX_READ) : 1;
	localparam int GIW = (MAX_GENOME > 1) ? $clog2(MAX_GENOME) : 1;
	localparam int DD  = MAX_READ * MAX_GENOME;
	localparam int DAW = (DD > 1) ? $clog2(DD) : 1;
	localparam int SD  = MAX_READ + MAX_GENOME;
	localparam int STW = $clog2(SD);
	localparam int SPW = $clog2(SD + 1);

	logic [3:0] mm_q, open_q, ext_q;

	logic [2:0] read_mem   [MAX_READ];
	logic [2:0] genome_mem [MAX_GENOME];
	logic signed [SW-1:0] score_mem [MAX_GENOME + 1];
	logic [1:0] dir_mem   [DD];
	logic [1:0] stack_mem [SD];

	logic [RW-1:0]  rl_q, i_q;
	logic [GW-1:0]  gl_q, bj_q;
	logic [JW-1:0]  j_q;
	logic [SPW-1:0] sp_q;
	logic [2:0]     rs_q;
	logic signed [SW-1:0] score_rd_q, diag_q, left_q, best_q;
	logic           left_d_q;
	logic [MAX_GENOME-1:0] upi_q;
	logic [1:0]     dir_rd_q, stk_rd_q;

	logic signed [SW-1:0] dg, lf, upv, v, sc_wdata;
	logic [1:0]     d, push_d;
	logic           agree, sc_we, sc_re, push;
	logic [SAW-1:0] sc_waddr, sc_raddr;
	logic [DAW-1:0] dir_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_q   <= 4'd6;
			open_q <= 4'd5;
			ext_q  <= 4'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MISMATCH: mm_q   <= cfg_data;
				CFG_OPEN:     open_q <= cfg_data;
				CFG_EXTEND:   ext_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign agree = (rs_q == WILDCARD) || (rs_q == genome_mem[GIW'(j_q - JW'(1))]);
	assign dg    = diag_q - (agree ? SW'(0) : SW'(mm_q));
	assign lf    = left_q - SW'(ext_q) - (left_d_q ? SW'(0) : SW'(open_q));
	assign upv   = score_rd_q - SW'(ext_q)
		- (upi_q[GIW'(j_q - JW'(1))] ? SW'(0) : SW'(open_q));

	always_comb begin
		priority if (lf >= dg && lf >= upv) begin
			v = lf;
			d = DIR_D;
		end else if (upv >= dg) begin
			v = upv;
			d = DIR_I;
		end else begin
			v = dg;
			d = DIR_M;
		end
	end

	assign dir_addr = DAW'((32'(i_q) - 32'd1) * MAX_GENOME + 32'(j_q) - 32'd1);

	always_comb begin
		sc_we    = 1'b0;
		sc_waddr = SAW'(j_q);
		sc_wdata = v;
		sc_re    = 1'b0;
		sc_raddr = SAW'(j_q);
		if (cmd.init) begin
			sc_we    = 1'b1;
			sc_wdata = (j_q == '0) ? SW'(0) : border(open_q, ext_q, 6'(j_q));
		end
		if (cmd.row_start) begin
			sc_we    = 1'b1;
			sc_waddr = '0;
			sc_wdata = border(open_q, ext_q, 6'(i_q));
			sc_re    = 1'b1;
			sc_raddr = SAW'(1);
		end
		if (cmd.cell_calc) begin
			sc_we    = 1'b1;
			sc_re    = !sts.j_eq_gl;
			sc_raddr = SAW'(j_q + JW'(1));
		end
		if (cmd.best) begin
			sc_re = !sts.best_done;
		end
	end

	always_comb begin
		push   = 1'b0;
		push_d = dir_rd_q;
		if (cmd.trace_step && (i_q == '0)) begin
			push   = 1'b1;
			push_d = DIR_D;
		end else if (cmd.trace_step && (j_q == '0)) begin
			push   = 1'b1;
			push_d = DIR_I;
		end else if (cmd.trace_use) begin
			push   = 1'b1;
			push_d = (dir_rd_q == DIR_I || dir_rd_q == DIR_D) ? dir_rd_q : DIR_M;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_read && (32'(index) < MAX_READ)) read_mem[RIW'(index)] <= symbol;
		if (cmd.wr_genome && (32'(index) < MAX_GENOME)) genome_mem[GIW'(index)] <= symbol;
		if (sc_we) score_mem[sc_waddr] <= sc_wdata;
		if (sc_re) score_rd_q <= score_mem[sc_raddr];
		if (cmd.cell_calc) dir_mem[dir_addr] <= d;
		if (cmd.trace_step) dir_rd_q <= dir_mem[dir_addr];
		if (push) stack_mem[sp_q[STW-1:0]] <= push_d;
		if (cmd.pop) stk_rd_q <= stack_mem[STW'(sp_q - SPW'(1))];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rl_q <= (32'(read_length) > MAX_READ) ? RW'(MAX_READ) : RW'(read_length);
			gl_q <= (32'(genome_length) > MAX_GENOME) ? GW'(MAX_GENOME) : GW'(genome_length);
			bj_q <= '0;
		end
		if (cmd.launch) begin
			j_q   <= '0;
			i_q   <= RW'(1);
			upi_q <= '0;
		end
		if (cmd.init && !sts.j_eq_gl) j_q <= j_q + JW'(1);
		if (cmd.row_start) begin
			diag_q   <= (i_q == RW'(1)) ? SW'(0) : border(open_q, ext_q, 6'(i_q - RW'(1)));
			left_q   <= border(open_q, ext_q, 6'(i_q));
			left_d_q <= 1'b0;
			rs_q     <= read_mem[RIW'(i_q - RW'(1))];
			j_q      <= JW'(1);
		end
		if (cmd.cell_calc) begin
			left_q   <= v;
			left_d_q <= (d == DIR_D);
			diag_q   <= score_rd_q;
			upi_q[GIW'(j_q - JW'(1))] <= (d == DIR_I);
			if (sts.j_eq_gl) begin
				j_q <= '0;
				i_q <= i_q + RW'(1);
			end else begin
				j_q <= j_q + JW'(1);
			end
		end
		if (cmd.best) begin
			j_q <= j_q + JW'(1);
			if (j_q == JW'(1)) begin
				best_q <= score_rd_q;
				bj_q   <= '0;
			end else if (j_q != '0 && score_rd_q > best_q) begin
				best_q <= score_rd_q;
				bj_q   <= GW'(j_q - JW'(1));
			end
		end
		if (cmd.trace_init) begin
			i_q <= rl_q;
			j_q <= JW'(bj_q);
		end
		if (cmd.trace_step && i_q == '0) j_q <= j_q - JW'(1);
		if (cmd.trace_step && i_q != '0 && j_q == '0) i_q <= i_q - RW'(1);
		if (cmd.trace_use) begin
			if (dir_rd_q != DIR_D) i_q <= i_q - RW'(1);
			if (dir_rd_q != DIR_I) j_q <= j_q - JW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.trace_init) begin
			sp_q <= '0;
		end else if (push) begin
			sp_q <= sp_q + SPW'(1);
		end else if (cmd.pop) begin
			sp_q <= sp_q - SPW'(1);
		end
	end

	assign sts.rl_zero   = (rl_q == '0);
	assign sts.gl_zero   = (gl_q == '0);
	assign sts.j_eq_gl   = (j_q == JW'(gl_q));
	assign sts.i_eq_rl   = (i_q == rl_q);
	assign sts.best_done = (j_q == JW'(gl_q) + JW'(1));
	assign sts.i_zero    = (i_q == '0);
	assign sts.j_zero    = (j_q == '0);
	assign sts.sp_zero   = (sp_q == '0);

	assign op           = cmd.none ? OP_NONE : stk_rd_q;
	assign end_position = cmd.none ? 6'sd0 : $signed(6'(bj_q) - 6'd1);
	assign last         = cmd.none || sts.sp_zero;

endmodule

>>> hw/rtl/semiglobal_align_traceback_top.sv
// Affine-gap semiglobal aligner with traceback. A write transaction (mode 0 or 1) is taken
// from idle. A start fills the score grid one cell per cycle within a row (rows split by
// ST_ROWST) via the score row memory (one read and one write per cycle), scans the last row,
// traces back in ST_TR/ST_TRU (registered direction memory read) and gives each result via
// ST_POP/ST_OUT (registered path stack read); busy is high throughout. Results are shown for
// one cycle each under strobe, first op first, and the receiver cannot stall them.
module semiglobal_align_traceback_top
	import sat_pkg::*;
#(
	parameter int MAX_READ   = MAX_READ_DEF,
	parameter int MAX_GENOME = MAX_GENOME_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        mode,
	input  logic [4:0]        index,
	input  logic [2:0]        symbol,
	input  logic [5:0]        read_length,
	input  logic [5:0]        genome_length,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [3:0]        cfg_data,
	output logic              strobe,
	output logic [1:0]        op,
	output logic signed [5:0] end_position,
	output logic              last
);

	cmd_t cmd;
	sts_t sts;

	sat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe)
	);

	sat_dp #(
		.MAX_READ   (MAX_READ),
		.MAX_GENOME (MAX_GENOME)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.index         (index),
		.symbol        (symbol),
		.read_length   (read_length),
		.genome_length (genome_length),
		.op            (op),
		.end_position  (end_position),
		.last          (last)
	);

endmodule
